FILE: rtl/call_site_range_coalescer_top_assert.svh
// Assertion macros shared by the queue and back modules of the coalescer.
`ifndef CALL_SITE_RANGE_COALESCER_TOP_ASSERT_SVH
`define CALL_SITE_RANGE_COALESCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CSRC_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("call_site_range_coalescer: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define CSRC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("call_site_range_coalescer: next-cycle check failed");
`else
`define CSRC_ASSERT_SAME(label, clk, rst, cond, expr)
`define CSRC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

FILE: rtl/csrc_pkg.sv
`timescale 1ns / 1ps

package csrc_pkg;

   localparam int DEF_OFFSET_BITS = 32;
   localparam int DEF_ACTION_BITS = 16;
   localparam int DEF_COUNT_BITS  = 16;

   // Depth of the queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 4;

   localparam int OPCODE_BITS = 2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_SITE    = 2'd0,
      OP_BARRIER = 2'd1,
      OP_END     = 2'd2
   } opcode_type;

endpackage

FILE: rtl/csrc_front.sv
`timescale 1ns / 1ps

module csrc_front
   import csrc_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int ACTION_BITS = DEF_ACTION_BITS,
   parameter int ENTRY_BITS  = OPCODE_BITS + 3 * OFFSET_BITS + 1 + ACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OPCODE_BITS-1:0] req_opcode,
   input  logic [OFFSET_BITS-1:0] req_range_start,
   input  logic [OFFSET_BITS-1:0] req_range_length,
   input  logic [OFFSET_BITS-1:0] req_pad_offset,
   input  logic [ACTION_BITS-1:0] req_action_index,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [ENTRY_BITS-1:0]  push_data
);

   logic                  stage_valid_ff;
   logic                  stage_valid_in;
   logic [ENTRY_BITS-1:0] stage_data_ff;
   logic [ENTRY_BITS-1:0] stage_data_in;
   logic                  known_op;
   logic [OFFSET_BITS:0]  end_sum;

   assign req_ready  = !stage_valid_ff || push_ready;
   assign push_valid = stage_valid_ff;
   assign push_data  = stage_data_ff;

   // Ends carry one extra bit so that start plus length never wraps.
   assign end_sum = {1'b0, req_range_start} + {1'b0, req_range_length};

   always_comb begin
      case (opcode_type'(req_opcode))
         OP_SITE, OP_BARRIER, OP_END: known_op = 1'b1;
         default: known_op = 1'b0;
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff && !push_ready;
      stage_data_in  = stage_data_ff;
      if (req_valid && req_ready) begin
         // The unused opcode is dropped here and never reaches the queue.
         stage_valid_in = known_op;
         stage_data_in  = {req_opcode, req_range_start, end_sum,
                           req_pad_offset, req_action_index};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_data_ff <= stage_data_in;
   end

endmodule

FILE: rtl/csrc_queue.sv
`timescale 1ns / 1ps
`include "call_site_range_coalescer_top_assert.svh"

module csrc_queue
   import csrc_pkg::*;
#(
   parameter int ENTRY_BITS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [ENTRY_BITS-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [ENTRY_BITS-1:0] pop_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [ENTRY_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  push_fire;
   logic                  pop_fire;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The fill count never exceeds the depth and, below full, matches the pointer distance.
   `CSRC_ASSERT_SAME(a_queue_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(QUEUE_DEPTH))
   `CSRC_ASSERT_SAME(a_queue_ptr_match, clock, reset, count_ff != CNT_BITS'(QUEUE_DEPTH), (wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_BITS-1:0])

endmodule

FILE: rtl/csrc_back.sv
`timescale 1ns / 1ps
`include "call_site_range_coalescer_top_assert.svh"

module csrc_back
   import csrc_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int ACTION_BITS = DEF_ACTION_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS,
   parameter int ENTRY_BITS  = OPCODE_BITS + 3 * OFFSET_BITS + 1 + ACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic [ENTRY_BITS-1:0]  pop_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_entry_valid,
   output logic [OFFSET_BITS-1:0] rsp_out_start,
   output logic [OFFSET_BITS:0]   rsp_out_length,
   output logic [OFFSET_BITS-1:0] rsp_out_pad,
   output logic [ACTION_BITS-1:0] rsp_out_action,
   output logic                   rsp_is_last,
   output logic [COUNT_BITS-1:0]  rsp_kept_count,
   output logic [COUNT_BITS-1:0]  rsp_merged_count
);

   localparam int PAD_LSB   = ACTION_BITS;
   localparam int END_LSB   = PAD_LSB + OFFSET_BITS;
   localparam int START_LSB = END_LSB + OFFSET_BITS + 1;
   localparam int OP_LSB    = START_LSB + OFFSET_BITS;

   // Fields of the item at the head of the queue.
   opcode_type             item_op;
   logic [OFFSET_BITS-1:0] item_start;
   logic [OFFSET_BITS:0]   item_end;
   logic [OFFSET_BITS-1:0] item_pad;
   logic [ACTION_BITS-1:0] item_action;

   // Pending range and per-function totals.
   logic                   pend_valid_ff, pend_valid_in;
   logic [OFFSET_BITS-1:0] pend_start_ff, pend_start_in;
   logic [OFFSET_BITS:0]   pend_end_ff, pend_end_in;
   logic [OFFSET_BITS-1:0] pend_pad_ff, pend_pad_in;
   logic [ACTION_BITS-1:0] pend_action_ff, pend_action_in;
   logic                   gap_valid_ff, gap_valid_in;
   logic [OFFSET_BITS-1:0] gap_start_ff, gap_start_in;
   logic [COUNT_BITS-1:0]  kept_ff, kept_in;
   logic [COUNT_BITS-1:0]  merged_ff, merged_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   entry_valid_ff, entry_valid_in;
   logic [OFFSET_BITS-1:0] out_start_ff, out_start_in;
   logic [OFFSET_BITS:0]   out_length_ff, out_length_in;
   logic [OFFSET_BITS-1:0] out_pad_ff, out_pad_in;
   logic [ACTION_BITS-1:0] out_action_ff, out_action_in;
   logic                   is_last_ff, is_last_in;
   logic [COUNT_BITS-1:0]  kept_out_ff, kept_out_in;
   logic [COUNT_BITS-1:0]  merged_out_ff, merged_out_in;

   logic                   blocked;
   logic                   merge;
   logic                   produces;
   logic                   out_free;
   logic                   pop_fire;
   logic [COUNT_BITS-1:0]  kept_inc;
   logic [OFFSET_BITS:0]   pend_length;

   assign item_op     = opcode_type'(pop_data[OP_LSB +: OPCODE_BITS]);
   assign item_start  = pop_data[START_LSB +: OFFSET_BITS];
   assign item_end    = pop_data[END_LSB +: OFFSET_BITS + 1];
   assign item_pad    = pop_data[PAD_LSB +: OFFSET_BITS];
   assign item_action = pop_data[ACTION_BITS-1:0];

   assign blocked     = gap_valid_ff && (gap_start_ff < item_start);
   assign merge       = !blocked && (item_pad == pend_pad_ff) &&
                        (item_action == pend_action_ff);
   assign kept_inc    = kept_ff + 1'b1;
   assign pend_length = pend_end_ff - {1'b0, pend_start_ff};
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (item_op)
         OP_SITE: produces = pend_valid_ff && !merge;
         OP_END:  produces = 1'b1;
         default: produces = 1'b0;
      endcase
   end

   // Items without a result retire even while the output register is full.
   assign pop_ready = !produces || out_free;
   assign pop_fire  = pop_valid && pop_ready;

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_start_in  = pend_start_ff;
      pend_end_in    = pend_end_ff;
      pend_pad_in    = pend_pad_ff;
      pend_action_in = pend_action_ff;
      gap_valid_in   = gap_valid_ff;
      gap_start_in   = gap_start_ff;
      kept_in        = kept_ff;
      merged_in      = merged_ff;
      if (pop_fire) begin
         case (item_op)
            OP_SITE: begin
               if (pend_valid_ff && merge) begin
                  if (item_end > pend_end_ff) begin
                     pend_end_in = item_end;
                  end
                  merged_in = merged_ff + 1'b1;
               end else begin
                  if (pend_valid_ff) begin
                     kept_in = kept_inc;
                  end
                  pend_valid_in  = 1'b1;
                  pend_start_in  = item_start;
                  pend_end_in    = item_end;
                  pend_pad_in    = item_pad;
                  pend_action_in = item_action;
                  gap_valid_in   = 1'b0;
                  gap_start_in   = '0;
               end
            end
            OP_BARRIER: begin
               if (pend_valid_ff && !gap_valid_ff && ({1'b0, item_start} >= pend_end_ff)) begin
                  gap_valid_in = 1'b1;
                  gap_start_in = item_start;
               end
            end
            OP_END: begin
               pend_valid_in  = 1'b0;
               pend_start_in  = '0;
               pend_end_in    = '0;
               pend_pad_in    = '0;
               pend_action_in = '0;
               gap_valid_in   = 1'b0;
               gap_start_in   = '0;
               kept_in        = '0;
               merged_in      = '0;
            end
            default: begin
               pend_valid_in = pend_valid_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      entry_valid_in = entry_valid_ff;
      out_start_in   = out_start_ff;
      out_length_in  = out_length_ff;
      out_pad_in     = out_pad_ff;
      out_action_in  = out_action_ff;
      is_last_in     = is_last_ff;
      kept_out_in    = kept_out_ff;
      merged_out_in  = merged_out_ff;
      if (pop_fire && produces) begin
         rsp_valid_in   = 1'b1;
         entry_valid_in = pend_valid_ff;
         out_start_in   = pend_valid_ff ? pend_start_ff : '0;
         out_length_in  = pend_valid_ff ? pend_length : '0;
         out_pad_in     = pend_valid_ff ? pend_pad_ff : '0;
         out_action_in  = pend_valid_ff ? pend_action_ff : '0;
         is_last_in     = (item_op == OP_END);
         kept_out_in    = pend_valid_ff ? kept_inc : kept_ff;
         merged_out_in  = merged_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff  <= 1'b0;
         pend_start_ff  <= '0;
         pend_end_ff    <= '0;
         pend_pad_ff    <= '0;
         pend_action_ff <= '0;
         gap_valid_ff   <= 1'b0;
         gap_start_ff   <= '0;
         kept_ff        <= '0;
         merged_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pend_valid_ff  <= pend_valid_in;
         pend_start_ff  <= pend_start_in;
         pend_end_ff    <= pend_end_in;
         pend_pad_ff    <= pend_pad_in;
         pend_action_ff <= pend_action_in;
         gap_valid_ff   <= gap_valid_in;
         gap_start_ff   <= gap_start_in;
         kept_ff        <= kept_in;
         merged_ff      <= merged_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      entry_valid_ff <= entry_valid_in;
      out_start_ff   <= out_start_in;
      out_length_ff  <= out_length_in;
      out_pad_ff     <= out_pad_in;
      out_action_ff  <= out_action_in;
      is_last_ff     <= is_last_in;
      kept_out_ff    <= kept_out_in;
      merged_out_ff  <= merged_out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_valid  = entry_valid_ff;
   assign rsp_out_start    = out_start_ff;
   assign rsp_out_length   = out_length_ff;
   assign rsp_out_pad      = out_pad_ff;
   assign rsp_out_action   = out_action_ff;
   assign rsp_is_last      = is_last_ff;
   assign rsp_kept_count   = kept_out_ff;
   assign rsp_merged_count = merged_out_ff;

   // A gap barrier only exists behind a pending range.
   `CSRC_ASSERT_SAME(a_back_gap_needs_pending, clock, reset, gap_valid_ff, pend_valid_ff)
   // The end item leaves no pending range behind.
   `CSRC_ASSERT_NEXT(a_back_end_clears, clock, reset, pop_fire && (item_op == OP_END), !pend_valid_ff && !gap_valid_ff)
   // A result is never loaded over one that is still waiting.
   `CSRC_ASSERT_SAME(a_back_no_overwrite, clock, reset, pop_fire && produces, out_free)

endmodule

FILE: rtl/call_site_range_coalescer_top.sv
`timescale 1ns / 1ps
// The item that causes a result passes the front stage register and the queue, and the
// result then sits in the output register for as long as the result channel stalls.
// The block takes one item per cycle while the result channel accepts results.
// The front stage and the queue let the input keep flowing while a result waits.
// Reset is synchronous and active high; it empties the front stage, the queue and the
// output register and clears the pending range and both counters.

module call_site_range_coalescer_top
   import csrc_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int ACTION_BITS = DEF_ACTION_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OPCODE_BITS-1:0] req_opcode,
   input  logic [OFFSET_BITS-1:0] req_range_start,
   input  logic [OFFSET_BITS-1:0] req_range_length,
   input  logic [OFFSET_BITS-1:0] req_pad_offset,
   input  logic [ACTION_BITS-1:0] req_action_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_entry_valid,
   output logic [OFFSET_BITS-1:0] rsp_out_start,
   output logic [OFFSET_BITS:0]   rsp_out_length,
   output logic [OFFSET_BITS-1:0] rsp_out_pad,
   output logic [ACTION_BITS-1:0] rsp_out_action,
   output logic                   rsp_is_last,
   output logic [COUNT_BITS-1:0]  rsp_kept_count,
   output logic [COUNT_BITS-1:0]  rsp_merged_count
);

   // One queue entry holds the opcode, the start, the widened end, the pad and the action.
   localparam int ENTRY_BITS = OPCODE_BITS + 3 * OFFSET_BITS + 1 + ACTION_BITS;

   logic                  push_valid;
   logic                  push_ready;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ENTRY_BITS-1:0] pop_data;

   // The front stage decodes the opcode, drops the unused code and forms the end
   // of each range, so that the back never has to add start and length itself.
   csrc_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .ACTION_BITS (ACTION_BITS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_range_start  (req_range_start),
      .req_range_length (req_range_length),
      .req_pad_offset   (req_pad_offset),
      .req_action_index (req_action_index),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // The queue decouples the two halves, so a stall on the result channel only
   // reaches the input once the queue has filled.
   csrc_queue #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // The back holds the pending range, merges matching sites into it, tracks the
   // first barrier in the gap and drives the registered result channel. Barriers
   // and merged sites retire without waiting for the result channel.
   csrc_back #(
      .OFFSET_BITS (OFFSET_BITS),
      .ACTION_BITS (ACTION_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_out_start    (rsp_out_start),
      .rsp_out_length   (rsp_out_length),
      .rsp_out_pad      (rsp_out_pad),
      .rsp_out_action   (rsp_out_action),
      .rsp_is_last      (rsp_is_last),
      .rsp_kept_count   (rsp_kept_count),
      .rsp_merged_count (rsp_merged_count)
   );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import csrc_pkg::*;

   localparam int OB = DEF_OFFSET_BITS;
   localparam int AB = DEF_ACTION_BITS;
   localparam int CB = DEF_COUNT_BITS;

   // Opcode 3 has no meaning; the block must drop it without touching its state.
   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

   // The run is bounded by this many clock cycles. The slowest correct run is
   // roughly 1900 items at the widest idle bounds on each side plus one long
   // receiver hold, which fits well within this bound.
   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int unsigned RANDOM_TARGET = 1850;
   localparam int unsigned LONG_HOLD_CYCLES = 100;
   localparam int unsigned DRAIN_CYCLES = 16;

   // One input item of the call site stream.
   typedef struct {
      logic [OPCODE_BITS-1:0] opcode;
      logic [OB-1:0]          range_start;
      logic [OB-1:0]          range_length;
      logic [OB-1:0]          pad_offset;
      logic [AB-1:0]          action_index;
   } call_item_type;

   // One coalesced range as it leaves the block.
   typedef struct {
      logic          entry_valid;
      logic [OB-1:0] start;
      logic [OB:0]   length;
      logic [OB-1:0] pad;
      logic [AB-1:0] action;
      logic          is_last;
      logic [CB-1:0] kept;
      logic [CB-1:0] merged;
   } coalesced_range_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [OPCODE_BITS-1:0] req_opcode;
   logic [OB-1:0]          req_range_start;
   logic [OB-1:0]          req_range_length;
   logic [OB-1:0]          req_pad_offset;
   logic [AB-1:0]          req_action_index;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_entry_valid;
   logic [OB-1:0]          rsp_out_start;
   logic [OB:0]            rsp_out_length;
   logic [OB-1:0]          rsp_out_pad;
   logic [AB-1:0]          rsp_out_action;
   logic                   rsp_is_last;
   logic [CB-1:0]          rsp_kept_count;
   logic [CB-1:0]          rsp_merged_count;

   call_site_range_coalescer_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_range_start  (req_range_start),
      .req_range_length (req_range_length),
      .req_pad_offset   (req_pad_offset),
      .req_action_index (req_action_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_out_start    (rsp_out_start),
      .rsp_out_length   (rsp_out_length),
      .rsp_out_pad      (rsp_out_pad),
      .rsp_out_action   (rsp_out_action),
      .rsp_is_last      (rsp_is_last),
      .rsp_kept_count   (rsp_kept_count),
      .rsp_merged_count (rsp_merged_count)
   );

   // 10 ns clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow copy of the coalescer state, advanced once per accepted transfer.
   logic          pend_valid = 1'b0;
   logic [OB-1:0] pend_start = '0;
   logic [OB:0]   pend_end = '0;
   logic [OB-1:0] pend_pad = '0;
   logic [AB-1:0] pend_action = '0;
   logic          gap_valid = 1'b0;
   logic [OB-1:0] gap_start = '0;
   logic [CB-1:0] kept_total = '0;
   logic [CB-1:0] merged_total = '0;

   // Ranges the block still owes us, oldest first.
   coalesced_range_type expected_ranges[$];

   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned functions_closed = 0;

   // Idle bounds for each side; zero gives a stretch with no idling at all.
   int unsigned sender_max_gap = 8;
   int unsigned receiver_max_gap = 8;
   int unsigned rsp_wait = 0;
   logic        rsp_hold = 1'b0;
   event        hold_kick;

   // Appends one range at the tail of the expected list.
   function automatic void owe_range(input coalesced_range_type r);
      expected_ranges.insert(expected_ranges.size(), r);
   endfunction

   // The pending range as it would appear on the result channel. A flush with
   // nothing pending reports zeroed range fields but still carries the counts.
   function automatic coalesced_range_type pending_as_result(input logic with_range,
                                                             input logic last);
      coalesced_range_type r;
      r.entry_valid = with_range;
      r.start       = with_range ? pend_start : '0;
      r.length      = with_range ? (pend_end - {1'b0, pend_start}) : '0;
      r.pad         = with_range ? pend_pad : '0;
      r.action      = with_range ? pend_action : '0;
      r.is_last     = last;
      r.kept        = kept_total;
      r.merged      = merged_total;
      return r;
   endfunction

   // A site that starts a new pending range also forgets any gap barrier.
   function automatic void open_range(input call_item_type it, input logic [OB:0] site_end);
      pend_valid  = 1'b1;
      pend_start  = it.range_start;
      pend_end    = site_end;
      pend_pad    = it.pad_offset;
      pend_action = it.action_index;
      gap_valid   = 1'b0;
      gap_start   = '0;
   endfunction

   // Advances the shadow state by one item and queues the range it produces, if any.
   function automatic void coalesce_item(input call_item_type it);
      logic [OB:0] site_end;
      logic        blocked;
      // Ends carry one extra bit so that start plus length never wraps.
      site_end = {1'b0, it.range_start} + {1'b0, it.range_length};
      case (it.opcode)
         OP_SITE: begin
            if (!pend_valid) begin
               open_range(it, site_end);
            end else begin
               blocked = gap_valid && (gap_start < it.range_start);
               if (!blocked && it.pad_offset == pend_pad
                   && it.action_index == pend_action) begin
                  // A site that ends early is absorbed without shrinking the range.
                  if (site_end > pend_end) begin
                     pend_end = site_end;
                  end
                  merged_total = merged_total + 1'b1;
               end else begin
                  kept_total = kept_total + 1'b1;
                  owe_range(pending_as_result(1'b1, 1'b0));
                  open_range(it, site_end);
               end
            end
         end
         OP_BARRIER: begin
            // Only the first barrier at or past the pending end counts as a gap.
            if (pend_valid && !gap_valid && {1'b0, it.range_start} >= pend_end) begin
               gap_valid = 1'b1;
               gap_start = it.range_start;
            end
         end
         OP_END: begin
            if (pend_valid) begin
               kept_total = kept_total + 1'b1;
               owe_range(pending_as_result(1'b1, 1'b1));
            end else begin
               owe_range(pending_as_result(1'b0, 1'b1));
            end
            pend_valid   = 1'b0;
            pend_start   = '0;
            pend_end     = '0;
            pend_pad     = '0;
            pend_action  = '0;
            gap_valid    = 1'b0;
            gap_start    = '0;
            kept_total   = '0;
            merged_total = '0;
            functions_closed++;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic call_item_type make_item(input logic [OPCODE_BITS-1:0] op,
                                               input logic [OB-1:0] s,
                                               input logic [OB-1:0] len,
                                               input logic [OB-1:0] pad,
                                               input logic [AB-1:0] act);
      call_item_type it;
      it.opcode       = op;
      it.range_start  = s;
      it.range_length = len;
      it.pad_offset   = pad;
      it.action_index = act;
      return it;
   endfunction

   // Offers one item after a random gap and waits for its transfer. Valid stays
   // high afterwards, so back-to-back items keep it up without a dip.
   task automatic send_item(input call_item_type it);
      int unsigned gap;
      gap = $urandom_range(0, sender_max_gap);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode       <= it.opcode;
      req_range_start  <= it.range_start;
      req_range_length <= it.range_length;
      req_pad_offset   <= it.pad_offset;
      req_action_index <= it.action_index;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      coalesce_item(it);
      items_sent++;
   endtask

   // Receiver: after each transfer it idles for a drawn number of cycles, and
   // it stays off entirely while a long hold is in force.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold || rsp_wait != 0) begin
         rsp_ready <= 1'b0;
         if (rsp_wait != 0) begin
            rsp_wait--;
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Long receiver stall, counted here so the sender can keep offering items
   // while the block's internal queue fills and it drops req_ready.
   initial begin
      forever begin
         @(hold_kick);
         @(negedge clock);
         rsp_hold <= 1'b1;
         repeat (LONG_HOLD_CYCLES) @(negedge clock);
         rsp_hold <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Every result transfer is matched against the oldest expected range.
   always @(posedge clock) begin : check_results
      coalesced_range_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ranges.size() == 0) begin
            $error("result transfer arrived with no range expected");
            error_count++;
         end else begin
            want = expected_ranges.pop_front();
            check_field("entry_valid", want.entry_valid, rsp_entry_valid);
            check_field("out_start", want.start, rsp_out_start);
            check_field("out_length", want.length, rsp_out_length);
            check_field("out_pad", want.pad, rsp_out_pad);
            check_field("out_action", want.action, rsp_out_action);
            check_field("is_last", want.is_last, rsp_is_last);
            check_field("kept_count", want.kept, rsp_kept_count);
            check_field("merged_count", want.merged, rsp_merged_count);
         end
         results_checked++;
         rsp_wait = $urandom_range(0, receiver_max_gap);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
         @(posedge clock);
      end
      $display("call_site_range_coalescer_top regression: fail");
      $finish;
   end

   // Hand-picked items: empty flush, ignored barrier and opcode, the widest
   // offsets and lengths, a site that ends inside the range, and the barrier
   // rules (below the end, held, second one dropped, equal start, blocking).
   task automatic test_directed_cases();
      send_item(make_item(OP_END, '0, '0, '0, '0));
      send_item(make_item(OP_BARRIER, 32'd100, '0, '0, '0));
      send_item(make_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
      send_item(make_item(OP_SITE, '0, '0, '0, '0));
      send_item(make_item(OP_SITE, '0, '0, '0, '0));
      send_item(make_item(OP_SITE, '1, '1, '1, '1));
      send_item(make_item(OP_SITE, '1, 32'd1, '1, '1));
      send_item(make_item(OP_END, '0, '0, '0, '0));
      // Widest range: from zero to the largest end that start plus length can reach.
      send_item(make_item(OP_SITE, '0, '1, 32'd5, 16'd7));
      send_item(make_item(OP_SITE, '1, '1, 32'd5, 16'd7));
      send_item(make_item(OP_BARRIER, 32'h10, '0, '0, '0));
      send_item(make_item(OP_END, '0, '0, '0, '0));
      send_item(make_item(OP_SITE, 32'd100, 32'd10, 32'd1, 16'd1));
      send_item(make_item(OP_BARRIER, 32'd105, '0, '0, '0));
      send_item(make_item(OP_BARRIER, 32'd120, '0, '0, '0));
      send_item(make_item(OP_BARRIER, 32'd115, '0, '0, '0));
      send_item(make_item(OP_SITE, 32'd120, 32'd5, 32'd1, 16'd1));
      send_item(make_item(OP_SITE, 32'd130, 32'd5, 32'd1, 16'd1));
      send_item(make_item(OP_SITE, 32'd140, 32'd5, 32'd2, 16'd1));
      send_item(make_item(OP_SITE, 32'd150, 32'd5, 32'd2, 16'd2));
      send_item(make_item(OP_END, '0, '0, '0, '0));
   endtask

   // Back-to-back sites that each close a range, offered while the receiver
   // is held off, so the block must stall its input.
   task automatic test_backpressure();
      int unsigned i;
      sender_max_gap = 0;
      -> hold_kick;
      for (i = 0; i < 40; i++) begin
         send_item(make_item(OP_SITE, 32'h1000 + 16 * i, 32'd8, 32'hA0 + i[0], 16'd9));
      end
      send_item(make_item(OP_END, '0, '0, '0, '0));
      sender_max_gap = 8;
   endtask

   // A short burst of unrelated items, which may include the unused opcode.
   task automatic send_noise_burst();
      int unsigned n;
      int unsigned i;
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
         send_item(make_item($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom));
      end
   endtask

   // One function: start-ordered sites drawn from two handlers so merges are
   // common, barriers dropped into the gaps, and mostly short lengths.
   task automatic send_function();
      logic [OB-1:0] cursor;
      logic [OB-1:0] pads[2];
      logic [AB-1:0] acts[2];
      logic [OB-1:0] len;
      int unsigned   n_sites;
      int unsigned   i;
      cursor  = ($urandom_range(0, 7) == 0) ? ('1 - $urandom_range(0, 255)) : $urandom;
      pads[0] = $urandom;
      pads[1] = pads[0] ^ (32'd1 << $urandom_range(0, OB - 1));
      acts[0] = $urandom;
      acts[1] = acts[0] ^ (16'd1 << $urandom_range(0, AB - 1));
      n_sites = $urandom_range(0, 12);
      for (i = 0; i < n_sites; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            cursor = cursor + $urandom_range(0, 16);
            send_item(make_item(OP_BARRIER, cursor, $urandom, $urandom, $urandom));
         end
         cursor = cursor + $urandom_range(0, 12);
         len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 24);
         send_item(make_item(OP_SITE, cursor, len,
                             pads[$urandom_range(0, 3) == 0],
                             acts[$urandom_range(0, 3) == 0]));
      end
      send_item(make_item(OP_END, $urandom, $urandom, $urandom, $urandom));
   endtask

   // Mostly well-formed functions, with some noise, and idling switched off
   // now and then on both sides.
   task automatic test_random_traffic();
      while (items_sent < RANDOM_TARGET) begin
         if ($urandom_range(0, 5) == 0) begin
            sender_max_gap   = 0;
            receiver_max_gap = 0;
         end else begin
            sender_max_gap   = 8;
            receiver_max_gap = 8;
         end
         if ($urandom_range(0, 6) == 0) begin
            send_noise_burst();
         end else begin
            send_function();
         end
      end
      sender_max_gap   = 8;
      receiver_max_gap = 8;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = '0;
      req_range_start  = '0;
      req_range_length = '0;
      req_pad_offset   = '0;
      req_action_index = '0;
      rsp_ready        = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_backpressure();
      test_random_traffic();

      // Stimulus is done; drop valid and let every owed range come out.
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_ranges.size() != 0) begin
         @(posedge clock);
      end
      // Keep running for DRAIN_CYCLES so that any stray extra result is caught.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_ranges.size() != 0) begin
         $error("%0d expected ranges never arrived", expected_ranges.size());
         error_count++;
      end

      $display("Ran %0d item transfers over %0d functions and checked %0d results,",
               items_sent, functions_closed, results_checked);
      $display("with barrier rules, noise items and a long receiver stall.");
      if (error_count == 0) begin
         $display("call_site_range_coalescer_top regression: pass");
      end else begin
         $display("call_site_range_coalescer_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/csrc_pkg.sv
rtl/csrc_front.sv
rtl/csrc_queue.sv
rtl/csrc_back.sv
rtl/call_site_range_coalescer_top.sv
sim/tb_top.sv
